FILE: hdl/prefix_lis_length_engine_unit_assert.svh
// assertion macros for the prefix lis length engine
// used by the top level; no dependencies
`ifndef PREFIX_LIS_LENGTH_ENGINE_UNIT_ASSERT_SVH
`define PREFIX_LIS_LENGTH_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LISL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lisl assertion failed");
`define LISL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lisl assertion failed");
`else
`define LISL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LISL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/lisl_pkg.sv
// shared types and constants for the prefix lis length engine
// no dependencies
`timescale 1ns / 1ps

package lisl_pkg;

    localparam int LISL_MAX_LEN = 1024;
    localparam int VALUE_W      = 32;
    localparam int LEN_W        = 11;

    typedef logic signed [VALUE_W-1:0] lisl_value_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic        accept;
        lisl_value_t value;
    } lisl_bcast_t;

endpackage

FILE: hdl/lisl_if.sv
// valid/ready channel interfaces for samples and results
// depends on lisl_pkg
`timescale 1ns / 1ps

interface lisl_sample_if
    import lisl_pkg::*;
();
    logic        valid;
    logic        ready;
    lisl_value_t sample_value;
    logic        first_of_sequence;

    modport source (output valid, sample_value, first_of_sequence, input ready);
    modport sink   (input valid, sample_value, first_of_sequence, output ready);
endinterface

interface lisl_length_if
    import lisl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] lis_length;
    logic             overflow;

    modport source (output valid, lis_length, overflow, input ready);
    modport sink   (input valid, lis_length, overflow, output ready);
endinterface

FILE: hdl/lisl_cell.sv
// one tail cell: holds one tail and compares it with the broadcast value
// depends on lisl_pkg
`timescale 1ns / 1ps

module lisl_cell
    import lisl_pkg::*;
#(
    parameter int CW  = 11,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  lisl_bcast_t   bcast,
    input  logic [CW-1:0] eff_count,
    input  logic          left_lt,
    output logic          lt,
    output logic          write,
    output logic          fresh
);

    lisl_value_t tail_reg;
    lisl_value_t tail_next;
    logic        occ;

    assign occ   = (eff_count > CW'(IDX));
    // tails are sorted, so lt is a run of ones then zeros along the row
    assign lt    = occ && (tail_reg < bcast.value);
    assign write = !lt && left_lt;
    assign fresh = write && !occ;

    always_comb
    begin
        tail_next = tail_reg;
        if (bcast.accept && write)
        begin
            tail_next = bcast.value;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
    end

endmodule

FILE: hdl/prefix_lis_length_engine_unit.sv
// channel      | dir | payload
// samples      | in  | sample_value (32 signed), first_of_sequence
// lengths      | out | lis_length (11), overflow
//
// one transaction per cycle: the value is broadcast to a row of MAX_LEN cells,
// each compares it with its tail and hands the result to its right neighbor.
// the result sits in an output register; a new sample is taken while it is
// being taken or when it is empty, so a stalled result holds the input back.
// reset clears the tail count and the output valid; tails are not cleared.
// top level of the prefix lis length engine; depends on lisl_pkg, lisl_if,
// lisl_cell and prefix_lis_length_engine_unit_assert.svh
`timescale 1ns / 1ps
`include "prefix_lis_length_engine_unit_assert.svh"

module prefix_lis_length_engine_unit
    import lisl_pkg::*;
#(
    parameter int MAX_LEN = LISL_MAX_LEN
)
(
    input  logic          clk,
    input  logic          rst_n,
    lisl_sample_if.sink   samples,
    lisl_length_if.source lengths
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      eff_count;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               accept;
    logic               append;
    logic               ovf;
    lisl_bcast_t        bcast;
    logic [MAX_LEN:0]   lt_chain;
    logic [MAX_LEN-1:0] write_vec;
    logic [MAX_LEN-1:0] fresh_vec;
    logic [CW+LEN_W-1:0] len_wide;

    assign samples.ready = !out_valid_reg || lengths.ready;
    assign accept        = samples.valid && samples.ready;

    assign eff_count    = samples.first_of_sequence ? '0 : count_reg;
    assign bcast.accept = accept;
    assign bcast.value  = samples.sample_value;
    assign lt_chain[0]  = 1'b1;

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        lisl_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .bcast     (bcast),
            .eff_count (eff_count),
            .left_lt   (lt_chain[i]),
            .lt        (lt_chain[i+1]),
            .write     (write_vec[i]),
            .fresh     (fresh_vec[i])
        );
    end

    assign append   = |fresh_vec;
    // every cell below the value means the store is full
    assign ovf      = lt_chain[MAX_LEN];
    assign len_wide = {{LEN_W{1'b0}}, count_next};

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = eff_count + CW'(append);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            len_next       = len_wide[LEN_W-1:0];
            ovf_next       = ovf;
        end
        else if (lengths.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        ovf_reg <= ovf_next;
    end

    assign lengths.valid      = out_valid_reg;
    assign lengths.lis_length = len_reg;
    assign lengths.overflow   = ovf_reg;

    `LISL_ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(MAX_LEN))
    `LISL_ASSERT_IMPLIES(a_one_write, clk, rst_n, accept, $onehot0(write_vec))
    `LISL_ASSERT_IMPLIES(a_ovf_no_write, clk, rst_n, accept && ovf, write_vec == '0)
    `LISL_ASSERT_IMPLIES(a_write_or_ovf, clk, rst_n, accept, ovf || (write_vec != '0))
    `LISL_ASSERT_NEXT(a_len, clk, rst_n, accept, out_valid_reg && (len_reg == LEN_W'(count_reg)))

endmodule

FILE: sim/tb_prefix_lis_length_engine_unit.sv
// self-checking testbench for prefix_lis_length_engine_unit: random and directed samples,
// a scoreboard class tracks the tails and checks every length transaction
// depends on lisl_pkg, lisl_if and the engine rtl
`timescale 1ns / 1ps

module tb_prefix_lis_length_engine_unit;
    import lisl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct {
        logic [LEN_W-1:0] lis_length;
        logic             overflow;
    } length_item_t;

    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_RISING,
        MIX_EDGE
    } value_mix_t;

    class lis_length_scoreboard;
        lisl_value_t  tails[LISL_MAX_LEN];
        int unsigned  tail_count;
        length_item_t expected_lengths[$];
        int unsigned  mismatches;
        int unsigned  samples_seen;
        int unsigned  sequences_seen;
        int unsigned  lengths_checked;
        int unsigned  overflows_seen;
        int unsigned  longest_seen;

        function new();
            tail_count      = 0;
            mismatches      = 0;
            samples_seen    = 0;
            sequences_seen  = 0;
            lengths_checked = 0;
            overflows_seen  = 0;
            longest_seen    = 0;
        endfunction

        function void take_sample(lisl_value_t v, logic first);
            length_item_t item;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            logic         append;
            item.overflow = 1'b0;
            samples_seen++;
            if (first || tail_count == 0)
                sequences_seen++;
            if (first)
                tail_count = 0;
            if (tail_count == 0)
                append = 1'b1;
            else
                append = (v > tails[tail_count-1]);
            if (append) begin
                if (tail_count < LISL_MAX_LEN) begin
                    tails[tail_count] = v;
                    tail_count++;
                end
                else begin
                    item.overflow = 1'b1;
                end
            end
            else begin
                lo = 0;
                hi = tail_count;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (tails[mid] < v)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                tails[lo] = v;
            end
            item.lis_length = tail_count[LEN_W-1:0];
            expected_lengths = {expected_lengths, item};
        endfunction

        function void compare_length(logic [LEN_W-1:0] len, logic ovf);
            length_item_t want;
            if (expected_lengths.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] length transaction with no sample pending: len=%0d ovf=%0b",
                             $realtime, len, ovf);
                return;
            end
            want = expected_lengths.pop_front();
            lengths_checked++;
            if (ovf === 1'b1)
                overflows_seen++;
            if (len > longest_seen)
                longest_seen = len;
            if (len !== want.lis_length || ovf !== want.overflow) begin
                mismatches++;
                if (mismatches <= 10) begin
                    if (len !== want.lis_length)
                        $display("[%0t] lis_length: expected %0d, got %0d",
                                 $realtime, want.lis_length, len);
                    if (ovf !== want.overflow)
                        $display("[%0t] overflow: expected %0b, got %0b",
                                 $realtime, want.overflow, ovf);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_lengths.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lisl_sample_if samples_ch ();
    lisl_length_if lengths_ch ();

    prefix_lis_length_engine_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .lengths (lengths_ch)
    );

    lis_length_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_request;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned cycle_count;

    always #5 clk = ~clk;

    // receiver side: random ready, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            lengths_ch.ready = 1'b0;
            hold_left--;
        end
        else begin
            lengths_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (samples_ch.valid && samples_ch.ready)
                sb.take_sample(samples_ch.sample_value, samples_ch.first_of_sequence);
            if (lengths_ch.valid && lengths_ch.ready)
                sb.compare_length(lengths_ch.lis_length, lengths_ch.overflow);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("prefix_lis_length_engine_unit: mismatch");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays high for a following transaction
    task automatic send_sample(input lisl_value_t v, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            samples_ch.valid             = 1'b0;
            samples_ch.sample_value      = $urandom;
            samples_ch.first_of_sequence = $urandom_range(1);
            @(negedge clk);
        end
        samples_ch.valid             = 1'b1;
        samples_ch.sample_value      = v;
        samples_ch.first_of_sequence = first;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        samples_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic lisl_value_t next_value(value_mix_t mix, lisl_value_t prev);
        lisl_value_t v;
        case (mix)
            MIX_NARROW: v = lisl_value_t'(int'($urandom_range(0, 15)) - 8);
            MIX_RISING: v = prev + lisl_value_t'(int'($urandom_range(0, 60)) - 10);
            MIX_EDGE: begin
                case ($urandom_range(0, 6))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh8000_0001;
                    2: v = -32'sd1;
                    3: v = 32'sd0;
                    4: v = 32'sd1;
                    5: v = 32'sh7fff_fffe;
                    default: v = 32'sh7fff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic run_directed();
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd4, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b1);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shaaaa_aaaa, 1'b1);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'sd9, 1'b1);
        send_sample(32'sd2, 1'b0);
        send_sample(32'sd2, 1'b0);
    endtask

    task automatic run_sequences(input int unsigned n_items);
        int unsigned sent;
        int unsigned seq_len;
        int unsigned i;
        value_mix_t  mix;
        logic        flag_start;
        logic        first;
        lisl_value_t v;
        sent = 0;
        while (sent < n_items) begin
            seq_len    = $urandom_range(1, 40);
            mix        = value_mix_t'($urandom_range(0, 3));
            flag_start = ($urandom_range(9) != 0);
            v          = $urandom;
            for (i = 0; i < seq_len; i++) begin
                v     = next_value(mix, v);
                first = (i == 0) ? flag_start : ($urandom_range(49) == 0);
                send_sample(v, first);
                sent++;
            end
        end
    endtask

    initial begin
        sb                           = new();
        clk                          = 1'b0;
        rst_n                        = 1'b0;
        cycle_count                  = 0;
        hold_request                 = 0;
        hold_seen                    = 0;
        hold_left                    = 0;
        send_idle_pct                = 12;
        recv_idle_pct                = 73;
        samples_ch.valid             = 1'b0;
        samples_ch.sample_value      = '0;
        samples_ch.first_of_sequence = 1'b0;
        lengths_ch.ready             = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_sequences(130);
        drain();

        send_idle_pct = 73;
        recv_idle_pct = 12;
        run_sequences(130);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request++;
        run_sequences(40);
        drain();
        run_sequences(100);
        drain();
        repeat (20) @(posedge clk);

        $display("run covered %0d samples in %0d sequences, %0d lengths checked",
                 sb.samples_seen, sb.sequences_seen, sb.lengths_checked);
        $display("overflow transactions seen: %0d, longest length reported: %0d",
                 sb.overflows_seen, sb.longest_seen);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("prefix_lis_length_engine_unit: match");
        else
            $display("prefix_lis_length_engine_unit: mismatch");
        $finish;
    end

endmodule
